[rtl/bta_pkg.sv]
// Shared constants, codes and sequencer state type for the block table allocator.
package bta_pkg;

    // Table geometry: block count and block size are powers of two
    localparam int BLOCKS_LOG2 = 10;
    localparam int NUM_BLOCKS  = 1 << BLOCKS_LOG2;
    localparam int BLOCK_LOG2  = 5;
    localparam int BLOCK_BYTES = 1 << BLOCK_LOG2;
    localparam int NUM_POOLS   = 2;
    localparam int POOL_W      = 1;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SIZE_W   = 16;
    localparam int OFFS_W   = 16;
    localparam int STATUS_W = 2;
    localparam int AOFF_W   = 15;
    localparam int USAGE_W  = 7;

    // Derived widths
    localparam int IDX_W      = BLOCKS_LOG2;
    localparam int CNT_W      = IDX_W + 1;
    localparam int ENTRY_W    = 11;
    localparam int ADDR_W     = POOL_W + IDX_W;
    localparam int TBL_DEPTH  = NUM_POOLS * NUM_BLOCKS;
    localparam int NEED_W     = SIZE_W - BLOCK_LOG2 + 1;
    localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
    localparam int PCT_SCALE  = 100;
    localparam int PROD_W     = CNT_W + 7;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ALLOC_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FREE_FAIL  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_MARK,
        S_FREE_RD,
        S_FREE_CHK,
        S_FINISH
    } state_t;

endpackage

[rtl/bta_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
module bta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/block_table_allocator.sv]
// Top level of the block table allocator: sequencer, pool counters and table RAM.
//
// Usage: raise start with opcode, pool, size_bytes and offset_bytes while busy is
// low; the transfer happens at that clock edge and busy rises. The block holds one
// request at a time. When the request is finished, done is high for exactly one
// cycle with status, alloc_offset and usage_percent valid; the receiver cannot
// stall it. busy is already low in that cycle, so a new request may be taken then.
// Steps per request: an opcode other than allocate and free, an allocate refused on
// size and a rejected free go straight to the finish state. An allocate scans entries
// from the top index downward (at most 1024) for a free run, then marks the run. A
// free visits at least one entry, with one read and one write slot per entry.
// The scan reads one entry per cycle through the registered RAM read; marking
// writes one entry per cycle.
// Reset: every one of the 2048 table entries is written to zero, one entry per
// cycle, during which busy stays high. Pools start not ready and with zero
// usage.
module block_table_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bta_pkg::OP_W-1:0]          opcode,
    input  logic [bta_pkg::POOL_W-1:0]        pool,
    input  logic [bta_pkg::SIZE_W-1:0]        size_bytes,
    input  logic [bta_pkg::OFFS_W-1:0]        offset_bytes,
    output logic                              done,
    output logic [bta_pkg::STATUS_W-1:0]      status,
    output logic [bta_pkg::AOFF_W-1:0]        alloc_offset,
    output logic [bta_pkg::USAGE_W-1:0]       usage_percent
);

    // Sequencer and control registers
    bta_pkg::state_t                  state_reg, state_next;
    logic [bta_pkg::ADDR_W-1:0]       clr_reg, clr_next;
    logic                             scan_more_reg, scan_more_next;
    logic                             rd_vld_reg, rd_vld_next;
    logic                             done_reg, done_next;
    logic                             ready_reg [bta_pkg::NUM_POOLS];
    logic                             ready_next [bta_pkg::NUM_POOLS];
    logic [bta_pkg::CNT_W-1:0]        used_reg [bta_pkg::NUM_POOLS];
    logic [bta_pkg::CNT_W-1:0]        used_next [bta_pkg::NUM_POOLS];

    // Working payload registers
    logic [bta_pkg::POOL_W-1:0]       pool_reg, pool_next;
    logic [bta_pkg::NEED_W-1:0]       need_reg, need_next;
    logic [bta_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [bta_pkg::IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [bta_pkg::CNT_W-1:0]        run_reg, run_next;
    logic [bta_pkg::ENTRY_W-1:0]      rem_reg, rem_next;
    logic                             first_reg, first_next;
    logic [bta_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [bta_pkg::AOFF_W-1:0]       aoff_reg, aoff_next;
    logic [bta_pkg::USAGE_W-1:0]      usage_reg, usage_next;

    // Table RAM port
    logic                             ram_we;
    logic [bta_pkg::ADDR_W-1:0]       ram_waddr;
    logic [bta_pkg::ENTRY_W-1:0]      ram_wdata;
    logic                             ram_re;
    logic [bta_pkg::ADDR_W-1:0]       ram_raddr;
    logic [bta_pkg::ENTRY_W-1:0]      ram_rdata;

    // Decode of the incoming request
    logic                             accept;
    logic [bta_pkg::SIZE_W:0]         size_sum;
    logic [bta_pkg::NEED_W-1:0]       need_in;
    logic                             alloc_bad;
    logic                             free_range_bad;
    logic [bta_pkg::IDX_W-1:0]        free_idx;

    // Scan, free and mark conditions
    logic                             scan_eval;
    logic [bta_pkg::CNT_W-1:0]        run_inc;
    logic                             scan_hit;
    logic                             scan_end;
    logic [bta_pkg::ENTRY_W-1:0]      rem_cur;
    logic [bta_pkg::ENTRY_W-1:0]      rem_dec;
    logic                             rem_zero;
    logic                             free_end;
    logic                             mark_end;
    logic [bta_pkg::PROD_W-1:0]       usage_prod;

    assign accept = start && !busy;

    // Round the size up to whole blocks
    assign size_sum       = {1'b0, size_bytes} + (bta_pkg::SIZE_W + 1)'(bta_pkg::BLOCK_BYTES - 1);
    assign need_in        = size_sum[bta_pkg::SIZE_W:bta_pkg::BLOCK_LOG2];
    assign alloc_bad      = (size_bytes == '0) ||
                            (need_in > bta_pkg::NEED_W'(bta_pkg::NUM_BLOCKS));
    assign free_range_bad = ({1'b0, offset_bytes} >=
                             (bta_pkg::OFFS_W + 1)'(bta_pkg::POOL_BYTES));
    assign free_idx       = offset_bytes[bta_pkg::BLOCK_LOG2 +: bta_pkg::IDX_W];

    // Free-run scan: one entry arrives from the RAM per cycle
    assign scan_eval = (state_reg == bta_pkg::S_ALLOC_SCAN) && rd_vld_reg;
    assign run_inc   = (ram_rdata == '0) ? run_reg + 1'b1 : '0;
    assign scan_hit  = scan_eval && (bta_pkg::NEED_W'(run_inc) == need_reg);
    assign scan_end  = scan_eval && !scan_hit && (rd_idx_reg == '0);

    // Free walk: the head entry gives the count, later entries use the remainder
    assign rem_cur  = first_reg ? ram_rdata : rem_reg;
    assign rem_zero = (rem_cur == '0);
    assign rem_dec  = rem_cur - 1'b1;
    assign free_end = rem_zero || (rem_dec == '0) ||
                      (idx_reg == bta_pkg::IDX_W'(bta_pkg::NUM_BLOCKS - 1));

    // Mark walk ends on the last entry of the run
    assign mark_end = (rem_reg == bta_pkg::ENTRY_W'(1));

    // Usage: used * 100 / NUM_BLOCKS, the division being a shift
    assign usage_prod = bta_pkg::PROD_W'(used_reg[pool_reg]) *
                        bta_pkg::PROD_W'(bta_pkg::PCT_SCALE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bta_pkg::S_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = bta_pkg::S_IDLE;
                end
            end
            bta_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        bta_pkg::OP_ALLOC:
                        begin
                            state_next = alloc_bad ? bta_pkg::S_FINISH
                                                   : bta_pkg::S_ALLOC_SCAN;
                        end
                        bta_pkg::OP_FREE:
                        begin
                            if (!ready_reg[pool] || free_range_bad)
                            begin
                                state_next = bta_pkg::S_FINISH;
                            end
                            else
                            begin
                                state_next = bta_pkg::S_FREE_RD;
                            end
                        end
                        default:
                        begin
                            state_next = bta_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            bta_pkg::S_ALLOC_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = bta_pkg::S_ALLOC_MARK;
                end
                else if (scan_end)
                begin
                    state_next = bta_pkg::S_FINISH;
                end
            end
            bta_pkg::S_ALLOC_MARK:
            begin
                if (mark_end)
                begin
                    state_next = bta_pkg::S_FINISH;
                end
            end
            bta_pkg::S_FREE_RD:
            begin
                state_next = bta_pkg::S_FREE_CHK;
            end
            bta_pkg::S_FREE_CHK:
            begin
                state_next = free_end ? bta_pkg::S_FINISH : bta_pkg::S_FREE_RD;
            end
            bta_pkg::S_FINISH:
            begin
                state_next = bta_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bta_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result values
    always_comb
    begin
        clr_next       = clr_reg;
        scan_more_next = scan_more_reg;
        rd_vld_next    = 1'b0;
        done_next      = 1'b0;
        pool_next      = pool_reg;
        need_next      = need_reg;
        idx_next       = idx_reg;
        rd_idx_next    = rd_idx_reg;
        run_next       = run_reg;
        rem_next       = rem_reg;
        first_next     = first_reg;
        status_next    = status_reg;
        aoff_next      = aoff_reg;
        usage_next     = usage_reg;
        for (int p = 0; p < bta_pkg::NUM_POOLS; p++)
        begin
            ready_next[p] = ready_reg[p];
            used_next[p]  = used_reg[p];
        end
        ram_we    = 1'b0;
        ram_waddr = {pool_reg, idx_reg};
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = {pool_reg, idx_reg};

        case (state_reg)
            bta_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            bta_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    pool_next   = pool;
                    status_next = bta_pkg::STAT_OK;
                    aoff_next   = '0;
                    case (opcode)
                        bta_pkg::OP_ALLOC:
                        begin
                            // A fresh pool's table is already zero
                            ready_next[pool] = 1'b1;
                            need_next        = need_in;
                            idx_next         = bta_pkg::IDX_W'(bta_pkg::NUM_BLOCKS - 1);
                            scan_more_next   = 1'b1;
                            run_next         = '0;
                            if (alloc_bad)
                            begin
                                status_next = bta_pkg::STAT_ALLOC_FAIL;
                            end
                        end
                        bta_pkg::OP_FREE:
                        begin
                            idx_next   = free_idx;
                            first_next = 1'b1;
                            if (!ready_reg[pool])
                            begin
                                ready_next[pool] = 1'b1;
                                status_next      = bta_pkg::STAT_FREE_FAIL;
                            end
                            else if (free_range_bad)
                            begin
                                status_next = bta_pkg::STAT_FREE_FAIL;
                            end
                        end
                        default:
                        begin
                            status_next = bta_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            bta_pkg::S_ALLOC_SCAN:
            begin
                // Issue reads from the top index downward
                ram_re      = scan_more_reg;
                rd_vld_next = scan_more_reg;
                rd_idx_next = idx_reg;
                if (scan_more_reg)
                begin
                    idx_next       = idx_reg - 1'b1;
                    scan_more_next = (idx_reg != '0);
                end
                // Evaluate the entry read in the previous cycle
                if (scan_eval)
                begin
                    run_next = run_inc;
                end
                if (scan_hit)
                begin
                    idx_next  = rd_idx_reg;
                    rem_next  = need_reg[bta_pkg::ENTRY_W-1:0];
                    aoff_next = bta_pkg::AOFF_W'({rd_idx_reg, bta_pkg::BLOCK_LOG2'(0)});
                    used_next[pool_reg] = used_reg[pool_reg] +
                                          need_reg[bta_pkg::CNT_W-1:0];
                end
                else if (scan_end)
                begin
                    status_next = bta_pkg::STAT_ALLOC_FAIL;
                end
            end
            bta_pkg::S_ALLOC_MARK:
            begin
                ram_we    = 1'b1;
                ram_wdata = need_reg[bta_pkg::ENTRY_W-1:0];
                idx_next  = idx_reg + 1'b1;
                rem_next  = rem_reg - 1'b1;
            end
            bta_pkg::S_FREE_RD:
            begin
                ram_re = 1'b1;
            end
            bta_pkg::S_FREE_CHK:
            begin
                first_next = 1'b0;
                rem_next   = rem_dec;
                if (!rem_zero && (ram_rdata != '0))
                begin
                    ram_we              = 1'b1;
                    used_next[pool_reg] = used_reg[pool_reg] - 1'b1;
                end
                if (!free_end)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            bta_pkg::S_FINISH:
            begin
                done_next  = 1'b1;
                usage_next = usage_prod[bta_pkg::BLOCKS_LOG2 +: bta_pkg::USAGE_W];
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bta_pkg::S_CLEAR;
            clr_reg       <= '0;
            scan_more_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
            for (int p = 0; p < bta_pkg::NUM_POOLS; p++)
            begin
                ready_reg[p] <= 1'b0;
                used_reg[p]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            scan_more_reg <= scan_more_next;
            rd_vld_reg    <= rd_vld_next;
            done_reg      <= done_next;
            for (int p = 0; p < bta_pkg::NUM_POOLS; p++)
            begin
                ready_reg[p] <= ready_next[p];
                used_reg[p]  <= used_next[p];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pool_reg   <= pool_next;
        need_reg   <= need_next;
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        run_reg    <= run_next;
        rem_reg    <= rem_next;
        first_reg  <= first_next;
        status_reg <= status_next;
        aoff_reg   <= aoff_next;
        usage_reg  <= usage_next;
    end

    // Block table for all pools
    bta_ram #(
        .WIDTH (bta_pkg::ENTRY_W),
        .DEPTH (bta_pkg::TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Outputs
    assign busy          = (state_reg != bta_pkg::S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign alloc_offset  = aoff_reg;
    assign usage_percent = usage_reg;

    // Checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_offset_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != bta_pkg::STAT_OK)) |-> (alloc_offset == '0))
        else $error("nonzero offset on a failed transfer");

    // Both pool counters, independent of the unreset pool register
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg[0] <= bta_pkg::CNT_W'(bta_pkg::NUM_BLOCKS)) &&
        (used_reg[bta_pkg::NUM_POOLS-1] <= bta_pkg::CNT_W'(bta_pkg::NUM_BLOCKS)))
        else $error("used entry count beyond table size");

endmodule
